### rtl/core/txc_pkg.sv
// Shared types and constants for the text console cursor engine.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package txc_pkg;

  // Field widths of the command and result ports
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned RROW_W   = 5;
  localparam int unsigned RCOL_W   = 7;
  localparam int unsigned CCOL_W   = 8;
  localparam int unsigned CROW_W   = 6;
  localparam int unsigned LLEN_W   = 8;

  // Geometry defaults
  localparam int unsigned ROWS_DEF     = 32;
  localparam int unsigned COLS_DEF     = 128;
  localparam int unsigned TAB_STOP_DEF = 4;

  localparam logic [LLEN_W-1:0] LINE_LENGTH_RST = 8'd128;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Recognised control bytes
  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;

  typedef enum logic [2:0] {
    OP_NL,
    OP_CR,
    OP_TAB,
    OP_BS,
    OP_PUT,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } txc_op_e;

  typedef struct packed {
    txc_op_e             op;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  color;
    logic [RROW_W-1:0]   read_row;
    logic [RCOL_W-1:0]   read_col;
  } txc_item_t;

  // Back-pressure seen by the front end
  typedef struct packed {
    logic q_full;
    logic init_busy;
  } txc_status_t;

endpackage

`default_nettype wire

### rtl/core/txc_front.sv
// Front end: takes commands, decodes them into operations for the queue.
// Depends on txc_pkg.
`default_nettype none

module txc_front (
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [txc_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [txc_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [txc_pkg::COLOR_W-1:0]   color_i,
  input  wire logic [txc_pkg::RROW_W-1:0]    read_row_i,
  input  wire logic [txc_pkg::RCOL_W-1:0]    read_col_i,
  input  wire txc_pkg::txc_status_t          status_i,
  output logic                               push_o,
  output txc_pkg::txc_item_t                 item_o
);

  txc_pkg::txc_op_e op;

  always_comb begin
    case (kind_i)
      txc_pkg::KIND_CHAR: begin
        case (char_code_i)
          txc_pkg::CH_NL:  op = txc_pkg::OP_NL;
          txc_pkg::CH_CR:  op = txc_pkg::OP_CR;
          txc_pkg::CH_TAB: op = txc_pkg::OP_TAB;
          txc_pkg::CH_BS:  op = txc_pkg::OP_BS;
          default:         op = txc_pkg::OP_PUT;
        endcase
      end
      txc_pkg::KIND_READ:  op = txc_pkg::OP_READ;
      txc_pkg::KIND_CLEAR: op = txc_pkg::OP_CLEAR;
      default:             op = txc_pkg::OP_NOP;
    endcase
  end

  assign busy_o = status_i.q_full | status_i.init_busy;
  assign push_o = start_i & ~busy_o;

  assign item_o.op        = op;
  assign item_o.char_code = char_code_i;
  assign item_o.color     = color_i;
  assign item_o.read_row  = read_row_i;
  assign item_o.read_col  = read_col_i;

endmodule

`default_nettype wire

### rtl/core/txc_queue.sv
// Short operation queue between front and back ends.
// Depends on txc_pkg.
`default_nettype none

module txc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire txc_pkg::txc_item_t item_i,
  input  wire logic               pop_i,
  output txc_pkg::txc_item_t      head_o,
  output logic                    empty_o,
  output logic                    full_o
);

  localparam int unsigned PW = (txc_pkg::QUEUE_DEPTH > 1) ? $clog2(txc_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(txc_pkg::QUEUE_DEPTH + 1);

  txc_pkg::txc_item_t entry_q [txc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(txc_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == NW'(txc_pkg::QUEUE_DEPTH));
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/txc_back.sv
// Back end: cursor, row-rotated cell memory, scroll and clear sweeps, results.
// Depends on txc_pkg.
`default_nettype none

module txc_back #(
  parameter int unsigned ROWS     = txc_pkg::ROWS_DEF,
  parameter int unsigned COLS     = txc_pkg::COLS_DEF,
  parameter int unsigned TAB_STOP = txc_pkg::TAB_STOP_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [txc_pkg::LLEN_W-1:0]    line_length_i,
  input  wire txc_pkg::txc_item_t            head_i,
  input  wire logic                          empty_i,
  output logic                               pop_o,
  output logic                               init_busy_o,
  output logic                               done_o,
  output logic                               cell_written_o,
  output logic [txc_pkg::RROW_W-1:0]         write_row_o,
  output logic [txc_pkg::RCOL_W-1:0]         write_col_o,
  output logic                               scrolled_o,
  output logic [txc_pkg::CCOL_W-1:0]         cursor_col_out_o,
  output logic [txc_pkg::CROW_W-1:0]         cursor_row_out_o,
  output logic [txc_pkg::CHAR_W-1:0]         read_char_o,
  output logic [txc_pkg::COLOR_W-1:0]        read_color_o
);

  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned PRW   = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS + 1);
  localparam int unsigned CAW   = $clog2(COLS);
  localparam int unsigned TW    = $clog2(COLS + TAB_STOP + 1);
  localparam int unsigned AW    = PRW + CAW;
  localparam int unsigned DEPTH = ROWS * (2 ** CAW);
  localparam int unsigned DW    = txc_pkg::COLOR_W + txc_pkg::CHAR_W;

  localparam logic [2:0] S_SWEEP  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_PUT    = 3'd4;
  localparam logic [2:0] S_READ   = 3'd5;

  localparam logic [DW-1:0] BLANK = {txc_pkg::COLOR_WHITE, txc_pkg::CH_SPACE};

  // cell memory, rows rotated by base_q
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  logic [2:0]     state_q, state_d;
  logic [AW-1:0]  sweep_q, sweep_d;
  logic           clr_q, clr_d;
  logic [PRW-1:0] srow_q, srow_d;
  logic [PRW-1:0] base_q, base_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic           scr_q, scr_d;
  txc_pkg::txc_item_t item_q, item_d;

  logic                         done_q, done_d;
  logic                         wrote_q, wrote_d;
  logic [txc_pkg::RROW_W-1:0]   wrow_q, wrow_d;
  logic [txc_pkg::RCOL_W-1:0]   wcol_q, wcol_d;
  logic                         scrolled_q, scrolled_d;
  logic [txc_pkg::CHAR_W-1:0]   rch_q, rch_d;
  logic [txc_pkg::COLOR_W-1:0]  rcolor_q, rcolor_d;

  logic [CW-1:0] cpl;
  logic [RW-1:0] row_inc;
  logic [TW-1:0] tab_tbl [COLS + 1];
  logic [TW-1:0] tab_next;
  logic          rd_ok;
  logic [CW-1:0] put_col, bs_col;
  logic [RW-1:0] put_row;

  function automatic logic [PRW-1:0] phys_row(input logic [PRW-1:0] r,
                                              input logic [PRW-1:0] b);
    logic [PRW:0] s;
    s = {1'b0, r} + {1'b0, b};
    if (s >= (PRW+1)'(ROWS)) begin
      s = s - (PRW+1)'(ROWS);
    end
    return s[PRW-1:0];
  endfunction

  // next tab stop for every reachable column
  for (genvar g = 0; g <= COLS; g++) begin : g_tab
    assign tab_tbl[g] = TW'((g / TAB_STOP + 1) * TAB_STOP);
  end

  always_comb begin
    if (line_length_i == '0) begin
      cpl = CW'(1);
    end else if (32'(line_length_i) > COLS) begin
      cpl = CW'(COLS);
    end else begin
      cpl = CW'(line_length_i);
    end
  end

  assign row_inc  = (row_q < RW'(ROWS)) ? row_q + 1'b1 : row_q;
  assign tab_next = tab_tbl[col_q];
  assign rd_ok    = (32'(item_q.read_row) < ROWS) && (32'(item_q.read_col) < COLS);
  assign bs_col   = col_q - 1'b1;
  assign put_col  = (col_q >= cpl) ? '0 : col_q;
  assign put_row  = (col_q >= cpl) ? row_inc : row_q;

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    clr_d      = clr_q;
    srow_d     = srow_q;
    base_d     = base_q;
    col_d      = col_q;
    row_d      = row_q;
    scr_d      = scr_q;
    item_d     = item_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = BLANK;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    done_d     = 1'b0;
    wrote_d    = wrote_q;
    wrow_d     = wrow_q;
    wcol_d     = wcol_q;
    scrolled_d = scrolled_q;
    rch_d      = rch_q;
    rcolor_d   = rcolor_q;

    case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
          if (clr_q) begin
            done_d     = 1'b1;
            wrote_d    = 1'b0;
            wrow_d     = '0;
            wcol_d     = '0;
            scrolled_d = 1'b0;
            rch_d      = '0;
            rcolor_d   = '0;
          end
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          item_d  = head_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        // defaults for a result given from this state
        wrote_d    = 1'b0;
        wrow_d     = '0;
        wcol_d     = '0;
        scrolled_d = 1'b0;
        rch_d      = '0;
        rcolor_d   = '0;
        state_d    = S_IDLE;
        case (item_q.op)
          txc_pkg::OP_NL: begin
            col_d  = '0;
            row_d  = row_inc;
            done_d = 1'b1;
          end
          txc_pkg::OP_CR: begin
            col_d  = '0;
            done_d = 1'b1;
          end
          txc_pkg::OP_TAB: begin
            if (tab_next >= TW'(cpl)) begin
              col_d = '0;
              row_d = row_inc;
            end else begin
              col_d = CW'(tab_next);
            end
            done_d = 1'b1;
          end
          txc_pkg::OP_BS: begin
            mem_wdata = {item_q.color, txc_pkg::CH_SPACE};
            if (col_q != '0) begin
              col_d = bs_col;
              if ((row_q < RW'(ROWS)) && (32'(bs_col) < COLS)) begin
                mem_we    = 1'b1;
                mem_waddr = {phys_row(PRW'(row_q), base_q), CAW'(bs_col)};
                wrote_d   = 1'b1;
                wrow_d    = txc_pkg::RROW_W'(row_q);
                wcol_d    = txc_pkg::RCOL_W'(bs_col);
              end
            end else if (row_q != '0) begin
              // step back over the row start to the end of the line above
              row_d     = row_q - 1'b1;
              col_d     = cpl - 1'b1;
              mem_we    = 1'b1;
              mem_waddr = {phys_row(PRW'(row_q - 1'b1), base_q), CAW'(cpl - 1'b1)};
              wrote_d   = 1'b1;
              wrow_d    = txc_pkg::RROW_W'(row_q - 1'b1);
              wcol_d    = txc_pkg::RCOL_W'(cpl - 1'b1);
            end
            done_d = 1'b1;
          end
          txc_pkg::OP_PUT: begin
            col_d = put_col;
            if (put_row >= RW'(ROWS)) begin
              // rotate rows, then blank the row that is now last
              row_d   = RW'(ROWS - 1);
              base_d  = (base_q == PRW'(ROWS - 1)) ? '0 : base_q + 1'b1;
              srow_d  = base_q;
              sweep_d = '0;
              scr_d   = 1'b1;
              state_d = S_SCROLL;
            end else begin
              row_d   = put_row;
              scr_d   = 1'b0;
              state_d = S_PUT;
            end
          end
          txc_pkg::OP_READ: begin
            mem_re    = rd_ok;
            mem_raddr = {phys_row(PRW'(item_q.read_row), base_q), CAW'(item_q.read_col)};
            state_d   = S_READ;
          end
          txc_pkg::OP_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            sweep_d = '0;
            clr_d   = 1'b1;
            state_d = S_SWEEP;
          end
          default: begin
            done_d = 1'b1;
          end
        endcase
      end

      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = {srow_q, sweep_q[CAW-1:0]};
        if (sweep_q[CAW-1:0] == CAW'(COLS - 1)) begin
          state_d = S_PUT;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end

      S_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = {phys_row(PRW'(row_q), base_q), CAW'(col_q)};
        mem_wdata  = {item_q.color, item_q.char_code};
        col_d      = col_q + 1'b1;
        done_d     = 1'b1;
        wrote_d    = 1'b1;
        wrow_d     = txc_pkg::RROW_W'(row_q);
        wcol_d     = txc_pkg::RCOL_W'(col_q);
        scrolled_d = scr_q;
        rch_d      = '0;
        rcolor_d   = '0;
        state_d    = S_IDLE;
      end

      S_READ: begin
        done_d     = 1'b1;
        wrote_d    = 1'b0;
        wrow_d     = '0;
        wcol_d     = '0;
        scrolled_d = 1'b0;
        rch_d      = rd_ok ? rdata_q[txc_pkg::CHAR_W-1:0] : '0;
        rcolor_d   = rd_ok ? rdata_q[DW-1:txc_pkg::CHAR_W] : '0;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      sweep_q <= '0;
      clr_q   <= 1'b0;
      base_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      clr_q   <= clr_d;
      base_q  <= base_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srow_q     <= srow_d;
    scr_q      <= scr_d;
    item_q     <= item_d;
    wrote_q    <= wrote_d;
    wrow_q     <= wrow_d;
    wcol_q     <= wcol_d;
    scrolled_q <= scrolled_d;
    rch_q      <= rch_d;
    rcolor_q   <= rcolor_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign init_busy_o      = (state_q == S_SWEEP) && !clr_q;
  assign done_o           = done_q;
  assign cell_written_o   = wrote_q;
  assign write_row_o      = wrow_q;
  assign write_col_o      = wcol_q;
  assign scrolled_o       = scrolled_q;
  assign cursor_col_out_o = txc_pkg::CCOL_W'(col_q);
  assign cursor_row_out_o = txc_pkg::CROW_W'(row_q);
  assign read_char_o      = rch_q;
  assign read_color_o     = rcolor_q;

endmodule

`default_nettype wire

### rtl/core/text_console_cursor_engine_unit.sv
// Top level of the text console cursor engine: front end, queue, back end.
// Depends on txc_pkg, txc_front, txc_queue and txc_back.
//
//  Channel   Direction  Handshake                    Payload
//  command   in         start_i, taken when !busy_o  kind, char_code, color, read_row/col
//  result    out        done_o, one-cycle strobe     cell_written ... read_color
//  config    in         cfg_we_i, no wait            cfg_wdata_i -> line_length
//
// A command is taken while busy_o is low and waits in a two-entry queue.
// The back end handles a control byte or kind 3 in its execute state, an
// ordinary byte through a write state, a read through a registered memory
// port, a byte that scrolls by first blanking one row, one cell a cycle,
// and a clear by sweeping the whole store, ROWS * 2**ceil(log2 COLS) cells,
// one cell a cycle. After reset the same sweep runs with busy_o high.
// Results cannot be held off; a strobe is dropped if ignored.
// busy_o rises only when the queue is full or the reset sweep runs.
`default_nettype none

module text_console_cursor_engine_unit #(
  parameter int unsigned ROWS     = txc_pkg::ROWS_DEF,
  parameter int unsigned COLS     = txc_pkg::COLS_DEF,
  parameter int unsigned TAB_STOP = txc_pkg::TAB_STOP_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [txc_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [txc_pkg::CHAR_W-1:0]    char_code_i,
  input  wire logic [txc_pkg::COLOR_W-1:0]   color_i,
  input  wire logic [txc_pkg::RROW_W-1:0]    read_row_i,
  input  wire logic [txc_pkg::RCOL_W-1:0]    read_col_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [txc_pkg::LLEN_W-1:0]    cfg_wdata_i,
  output logic                               done_o,
  output logic                               cell_written_o,
  output logic [txc_pkg::RROW_W-1:0]         write_row_o,
  output logic [txc_pkg::RCOL_W-1:0]         write_col_o,
  output logic                               scrolled_o,
  output logic [txc_pkg::CCOL_W-1:0]         cursor_col_out_o,
  output logic [txc_pkg::CROW_W-1:0]         cursor_row_out_o,
  output logic [txc_pkg::CHAR_W-1:0]         read_char_o,
  output logic [txc_pkg::COLOR_W-1:0]        read_color_o
);

  // line length register; only to be written while the engine is idle (not enforced)
  logic [txc_pkg::LLEN_W-1:0] line_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= txc_pkg::LINE_LENGTH_RST;
    end else if (cfg_we_i) begin
      line_length_q <= cfg_wdata_i;
    end
  end

  txc_pkg::txc_status_t status;
  txc_pkg::txc_item_t   push_item;
  txc_pkg::txc_item_t   head_item;
  logic                 push;
  logic                 pop;
  logic                 q_empty;
  logic                 q_full;
  logic                 init_busy;

  assign status.q_full    = q_full;
  assign status.init_busy = init_busy;

  // front end: decode each command into one queued operation
  txc_front u_front (
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .color_i     (color_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .status_i    (status),
    .push_o      (push),
    .item_o      (push_item)
  );

  txc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end: cursor, store, scroll and clear sweeps, result strobe
  txc_back #(
    .ROWS     (ROWS),
    .COLS     (COLS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .line_length_i    (line_length_q),
    .head_i           (head_item),
    .empty_i          (q_empty),
    .pop_o            (pop),
    .init_busy_o      (init_busy),
    .done_o           (done_o),
    .cell_written_o   (cell_written_o),
    .write_row_o      (write_row_o),
    .write_col_o      (write_col_o),
    .scrolled_o       (scrolled_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_row_out_o (cursor_row_out_o),
    .read_char_o      (read_char_o),
    .read_color_o     (read_color_o)
  );

endmodule

`default_nettype wire

### tb/sv/text_console_cursor_engine_unit_tb.sv
// Self-checking testbench for text_console_cursor_engine_unit: directed cases, then random traffic.
// Depends on txc_pkg and the RTL in rtl/core; the expected screen and cursor are modelled in-line.
module text_console_cursor_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import txc_pkg::*;

  localparam int N_ROWS  = ROWS_DEF;
  localparam int N_COLS  = COLS_DEF;
  localparam int TAB     = TAB_STOP_DEF;
  localparam int N_CELLS = N_ROWS * N_COLS;

  // kind 3 has no meaning in the block: it only reports the cursor
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic [31:0] BLANK_WORD = {COLOR_WHITE, CH_SPACE};

  // A clear sweeps 4096 cells; with a full queue behind it nothing is taken
  // meanwhile. The watchdog limit lies several times over that.
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               cell_written;
    logic [RROW_W-1:0]  write_row;
    logic [RCOL_W-1:0]  write_col;
    logic               scrolled;
    logic [CCOL_W-1:0]  cursor_col;
    logic [CROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0]  read_char;
    logic [COLOR_W-1:0] read_color;
  } console_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [KIND_W-1:0]  kind_i;
  logic [CHAR_W-1:0]  char_code_i;
  logic [COLOR_W-1:0] color_i;
  logic [RROW_W-1:0]  read_row_i;
  logic [RCOL_W-1:0]  read_col_i;
  logic               cfg_we_i;
  logic [LLEN_W-1:0]  cfg_wdata_i;
  logic               done_o;
  logic               cell_written_o;
  logic [RROW_W-1:0]  write_row_o;
  logic [RCOL_W-1:0]  write_col_o;
  logic               scrolled_o;
  logic [CCOL_W-1:0]  cursor_col_out_o;
  logic [CROW_W-1:0]  cursor_row_out_o;
  logic [CHAR_W-1:0]  read_char_o;
  logic [COLOR_W-1:0] read_color_o;

  // Shadow of the console: screen words are {colour, character}
  logic [31:0]       screen [N_CELLS];
  logic [CCOL_W-1:0] cur_col;
  logic [CROW_W-1:0] cur_row;
  logic [LLEN_W-1:0] line_len;

  console_result_t pending_results [$];
  int              fail_count;
  int              quiet_cycles;
  bit              gaps_on;

  text_console_cursor_engine_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .color_i          (color_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .done_o           (done_o),
    .cell_written_o   (cell_written_o),
    .write_row_o      (write_row_o),
    .write_col_o      (write_col_o),
    .scrolled_o       (scrolled_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cursor_row_out_o (cursor_row_out_o),
    .read_char_o      (read_char_o),
    .read_color_o     (read_color_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Console shadow
  // ---------------------------------------------------------------------------

  function automatic void blank_screen();
    for (int i = 0; i < N_CELLS; i++) screen[i] = BLANK_WORD;
  endfunction

  // The row saturates one past the last row; it never wraps back to 0
  function automatic void advance_row();
    if (cur_row < N_ROWS) cur_row = cur_row + 1'b1;
  endfunction

  // Writes at the cursor and records the write in the result
  function automatic void store_word(inout console_result_t r, input logic [31:0] word);
    screen[int'(cur_row) * N_COLS + int'(cur_col)] = word;
    r.cell_written = 1'b1;
    r.write_row    = cur_row[RROW_W-1:0];
    r.write_col    = cur_col[RCOL_W-1:0];
  endfunction

  // Applies one command to the shadow and returns the result it should produce
  function automatic console_result_t predict_command(input logic [KIND_W-1:0]  kind,
                                                      input logic [CHAR_W-1:0]  code,
                                                      input logic [COLOR_W-1:0] rgb,
                                                      input logic [RROW_W-1:0]  rrow,
                                                      input logic [RCOL_W-1:0]  rcol);
    console_result_t   r;
    logic [CCOL_W-1:0] cpl;
    logic [31:0]       word;
    r = '0;
    // zero acts as one, anything above the width is capped
    if (line_len == '0) cpl = 8'd1;
    else if (line_len > N_COLS) cpl = CCOL_W'(N_COLS);
    else cpl = line_len;

    case (kind)
      KIND_CHAR: begin
        if (code == CH_NL) begin
          cur_col = '0;
          advance_row();
        end else if (code == CH_CR) begin
          cur_col = '0;
        end else if (code == CH_TAB) begin
          cur_col = CCOL_W'((int'(cur_col) / TAB + 1) * TAB);
          if (cur_col >= cpl) begin
            cur_col = '0;
            advance_row();
          end
        end else if (code == CH_BS) begin
          if (cur_col != '0) begin
            cur_col = cur_col - 1'b1;
            // on the row past the end only the column moves
            if (cur_row < N_ROWS && cur_col < N_COLS) store_word(r, {rgb, CH_SPACE});
          end else if (cur_row != '0) begin
            cur_row = cur_row - 1'b1;
            cur_col = cpl - 1'b1;
            store_word(r, {rgb, CH_SPACE});
          end
        end else begin
          if (cur_col >= cpl) begin
            cur_col = '0;
            advance_row();
          end
          if (cur_row >= N_ROWS) begin
            for (int i = 0; i < N_CELLS - N_COLS; i++) screen[i] = screen[i + N_COLS];
            for (int i = N_CELLS - N_COLS; i < N_CELLS; i++) screen[i] = BLANK_WORD;
            r.scrolled = 1'b1;
            cur_row    = CROW_W'(N_ROWS - 1);
          end
          store_word(r, {rgb, code});
          cur_col = cur_col + 1'b1;
        end
      end
      KIND_READ: begin
        if (rrow < N_ROWS && rcol < N_COLS) begin
          word         = screen[int'(rrow) * N_COLS + int'(rcol)];
          r.read_char  = word[7:0];
          r.read_color = word[31:8];
        end
      end
      KIND_CLEAR: begin
        blank_screen();
        cur_col = '0;
        cur_row = '0;
      end
      default: ;
    endcase

    r.cursor_col = cur_col;
    r.cursor_row = cur_row;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Sampled at the rising edge, before the block's own updates land
  always @(posedge clk_i) begin
    console_result_t want;
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;

      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("cell_written",   want.cell_written, cell_written_o);
          check_field("write_row",      want.write_row,    write_row_o);
          check_field("write_col",      want.write_col,    write_col_o);
          check_field("scrolled",       want.scrolled,     scrolled_o);
          check_field("cursor_col_out", want.cursor_col,   cursor_col_out_o);
          check_field("cursor_row_out", want.cursor_row,   cursor_row_out_o);
          check_field("read_char",      want.read_char,    read_char_o);
          check_field("read_color",     want.read_color,   read_color_o);
        end
      end

      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("text_console_cursor_engine_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side. Every task starts and ends at a falling edge; send_command
  // leaves start_i high so back-to-back transfers need no gap.
  // ---------------------------------------------------------------------------

  task automatic send_command(input logic [KIND_W-1:0]  kind,
                              input logic [CHAR_W-1:0]  code,
                              input logic [COLOR_W-1:0] rgb,
                              input logic [RROW_W-1:0]  rrow,
                              input logic [RCOL_W-1:0]  rcol);
    start_i     = 1'b1;
    kind_i      = kind;
    char_code_i = code;
    color_i     = rgb;
    read_row_i  = rrow;
    read_col_i  = rcol;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_command(kind, code, rgb, rrow, rcol));
    @(negedge clk_i);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] code, input logic [COLOR_W-1:0] rgb);
    send_command(KIND_CHAR, code, rgb, '0, '0);
  endtask

  task automatic read_cell(input logic [RROW_W-1:0] rrow, input logic [RCOL_W-1:0] rcol);
    send_command(KIND_READ, '0, '0, rrow, rcol);
  endtask

  task automatic clear_all();
    send_command(KIND_CLEAR, '0, '0, '0, '0);
  endtask

  task automatic rest(input int cycles);
    start_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Sender holds off until every expected result has arrived, then a margin
  task automatic wait_drained();
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register writes only while the block is idle
  task automatic set_line_length(input logic [LLEN_W-1:0] value);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    line_len    = value;
  endtask

  // Mostly text and controls; reads lean towards the cells near the cursor
  task automatic send_random_command();
    int                 pick;
    logic [CHAR_W-1:0]  code;
    logic [COLOR_W-1:0] rgb;
    logic [RROW_W-1:0]  rrow;
    logic [RCOL_W-1:0]  rcol;
    pick = $urandom_range(0, 199);
    code = CHAR_W'($urandom_range(0, 255));
    rgb  = COLOR_W'($urandom);
    rrow = RROW_W'($urandom_range(0, 31));
    rcol = RCOL_W'($urandom_range(0, 127));
    if (pick < 100) begin
      put_char(code, rgb);
    end else if (pick < 125) begin
      put_char(CH_NL, rgb);
    end else if (pick < 135) begin
      put_char(CH_CR, rgb);
    end else if (pick < 150) begin
      put_char(CH_TAB, rgb);
    end else if (pick < 168) begin
      put_char(CH_BS, rgb);
    end else if (pick < 196) begin
      if (pick[0]) begin
        rrow = (cur_row >= N_ROWS) ? RROW_W'(N_ROWS - 1) : cur_row[RROW_W-1:0];
        if (rrow != '0 && $urandom_range(0, 1) == 1) rrow = rrow - 1'b1;
        rcol = (cur_col != '0) ? RCOL_W'(cur_col - 1'b1) : '0;
      end
      send_command(KIND_READ, code, rgb, rrow, rcol);
    end else if (pick < 198) begin
      send_command(KIND_NONE, code, rgb, rrow, rcol);
    end else begin
      send_command(KIND_CLEAR, code, rgb, rrow, rcol);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Store comes out of reset blank in white; the unused kind reports the cursor
  task automatic test_reset_contents();
    read_cell('0, '0);
    read_cell(5'h1F, 7'h7F);
    send_command(KIND_NONE, 8'hFF, 24'hFFFFFF, 5'h1F, 7'h7F);
  endtask

  task automatic test_text_and_controls();
    put_char(8'h41, 24'h000000);
    put_char(8'hFF, 24'hFFFFFF);
    put_char(8'h00, 24'hA5A5A5);
    put_char(CH_TAB, 24'h5A5A5A);
    put_char(CH_BS, 24'h123456);    // blanks column 3 in its colour
    put_char(CH_CR, 24'h000000);
    put_char(CH_NL, 24'h000000);
    read_cell('0, 7'd1);
    read_cell('0, 7'd3);
  endtask

  // Backspace at home does nothing; at a row start it steps back to the line end
  task automatic test_backspace_edges();
    clear_all();
    put_char(CH_BS, 24'hFFFFFF);
    put_char(8'h78, 24'h00FF00);
    put_char(CH_NL, 24'h000000);
    put_char(CH_BS, 24'h0000FF);
    read_cell('0, 7'h7F);
  endtask

  // Drive the cursor past the last row, then scroll back into the store
  task automatic test_row_saturation();
    repeat (N_ROWS + 1) put_char(CH_NL, 24'h000000);
    put_char(CH_TAB, 24'h000000);
    put_char(CH_BS, 24'hFF0000);    // missing row: column steps back, no write
    put_char(8'h5A, 24'h00FFFF);    // scrolls, lands on the last row
    put_char(CH_NL, 24'h000000);
    put_char(CH_BS, 24'hFF00FF);    // back from the missing row onto the last one
    read_cell(5'h1F, 7'd3);
    read_cell(5'h1E, '0);
  endtask

  task automatic test_line_length();
    clear_all();
    put_char(CH_TAB, 24'h000000);
    put_char(CH_TAB, 24'h000000);
    set_line_length(8'd4);          // cursor now sits beyond the line
    put_char(CH_BS, 24'h808080);
    put_char(8'h61, 24'h010203);    // wraps before writing
    put_char(CH_TAB, 24'h000000);   // wraps to the next row
    set_line_length(8'd0);          // treated as one column
    put_char(8'h62, 24'h040506);
    put_char(8'h63, 24'h070809);
    read_cell(5'd2, '0);
    set_line_length(8'hFF);         // capped at the store width
    put_char(8'h64, 24'hFEDCBA);
    set_line_length(LINE_LENGTH_RST);
  endtask

  task automatic test_clear();
    put_char(8'h7E, 24'h0F0F0F);
    clear_all();
    read_cell('0, '0);
    send_command(KIND_NONE, '0, '0, '0, '0);
  endtask

  // Random traffic over a range of line lengths. Gaps come in bursts and are
  // switched on and off per stretch; the last phase runs without gaps.
  task automatic test_random_traffic();
    logic [LLEN_W-1:0] lengths [12];
    int                per_phase;
    lengths   = '{8'd0, 8'd1, 8'd3, 8'd4, 8'd5, 8'd7, 8'd12, 8'd37,
                  8'd100, 8'd129, 8'd255, 8'd128};
    per_phase = 125;
    foreach (lengths[p]) begin
      set_line_length(lengths[p]);
      for (int i = 0; i < per_phase; i++) begin
        if (i % 40 == 0) gaps_on = (p != 11) && ($urandom_range(0, 2) != 0);
        send_random_command();
        if (p != 11 && i == per_phase / 2 && $urandom_range(0, 1) == 1) wait_drained();
        else if (gaps_on && $urandom_range(0, 3) == 0) rest($urandom_range(1, 4));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    kind_i       = '0;
    char_code_i  = '0;
    color_i      = '0;
    read_row_i   = '0;
    read_col_i   = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    gaps_on      = 1'b0;
    blank_screen();
    cur_col  = '0;
    cur_row  = '0;
    line_len = LINE_LENGTH_RST;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // The reset sweep holds busy_o high; the first transfer simply waits for it
    test_reset_contents();
    test_text_and_controls();
    test_backspace_edges();
    test_row_saturation();
    test_line_length();
    test_clear();
    test_random_traffic();

    wait_drained();
    if (fail_count == 0) begin
      $display("text_console_cursor_engine_unit: match");
    end else begin
      $display("text_console_cursor_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

### text_console_cursor_engine_unit.f
rtl/core/txc_pkg.sv
rtl/core/txc_front.sv
rtl/core/txc_queue.sv
rtl/core/txc_back.sv
rtl/core/text_console_cursor_engine_unit.sv
tb/sv/text_console_cursor_engine_unit_tb.sv
